>>> hw/rtl/hcd_pkg.sv
// shared types, constants and mod-26 helpers for the 3x3 hill decrypt core
// no dependencies
`default_nettype none

package hcd_pkg;

  localparam int LET_W  = 7;
  localparam int DIG_W  = 5;
  localparam int ROW_W  = 15;
  localparam int IDX_W  = 2;
  localparam int DATA_W = 24;

  localparam logic [LET_W-1:0] ASCII_A = 7'd65;

  // register indexes on the config port
  localparam logic [IDX_W-1:0] REG_KEY_ROW_A = 2'd0;
  localparam logic [IDX_W-1:0] REG_KEY_ROW_B = 2'd1;
  localparam logic [IDX_W-1:0] REG_KEY_ROW_C = 2'd2;

  localparam logic [ROW_W-1:0] KEY_ROW_A_RST = 15'd5681;
  localparam logic [ROW_W-1:0] KEY_ROW_B_RST = 15'd22101;
  localparam logic [ROW_W-1:0] KEY_ROW_C_RST = 15'd19522;

  typedef logic [DIG_W-1:0] digit_t;
  typedef digit_t [2:0] vec_t;
  typedef digit_t [2:0][2:0] mat_t;

  typedef struct packed {
    vec_t c;
    mat_t cof;
    vec_t row0;
  } cof_beat_t;

  typedef struct packed {
    vec_t   c;
    mat_t   cof;
    digit_t det;
  } det_beat_t;

  typedef struct packed {
    vec_t c;
    mat_t inv;
    logic bad;
  } inv_beat_t;

  // x mod 26 for x < 2048: reciprocal multiply never overshoots, one fix-up
  function automatic digit_t md26(input logic [10:0] x);
    logic [19:0] p;
    logic [10:0] r;
    p = 20'(x) * 20'd315;
    r = x - 11'(11'(p[19:13]) * 11'd26);
    if (r >= 11'd26) begin
      r = r - 11'd26;
    end
    return DIG_W'(r);
  endfunction

  // reduce a raw 5-bit key entry into 0..25
  function automatic digit_t red_entry(input logic [DIG_W-1:0] e);
    return (e >= 5'd26) ? 5'(e - 5'd26) : e;
  endfunction

  // inverse mod 26 of a unit; codes that are not units never reach use
  function automatic digit_t inv26(input digit_t d);
    digit_t r;
    unique case (d)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd1;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/hill_cipher_block_decrypt_core.sv
// Hill cipher 3x3 mod-26 block decryptor: key registers and four-stage pipeline.
// Uses hcd_pkg, hcd_cof, hcd_det, hcd_inv and hcd_mvmul.
//
// Usage: each in_ beat carries three ciphertext letters (ascii); each out_ beat
// carries the three plaintext letters and, in out_tuser, the key status
// (1 = key not invertible mod 26, letters are then all 'A').
// The key is three 15-bit rows written on cfg_we/cfg_idx/cfg_wdata; index 3
// is ignored. Write the key only while no beat is in flight.
// On its way from in_ to out_ a beat passes four register stages in order:
// cofactors, determinant, inverse, matrix product. Throughput: one beat per
// cycle while out_tready is high; the inverse key is recomputed per beat,
// so no setup time is needed after a key write.
// Each stage holds its beat until the next one frees up, so when out_tready
// is low the pipeline fills and in_tready drops once all four stages hold
// data; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default
// key rows 5681, 22101 and 19522.
`default_nettype none

module hill_cipher_block_decrypt_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // cipher_letter_first [6:0], cipher_letter_second [13:7],
  // cipher_letter_third [20:14], zero pad [23:21]
  input  wire logic [hcd_pkg::DATA_W-1:0] in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // plain_letter_first [6:0], plain_letter_second [13:7],
  // plain_letter_third [20:14], zero pad [23:21]
  output logic [hcd_pkg::DATA_W-1:0]      out_tdata,
  // key_status [0]
  output logic [0:0]                      out_tuser,
  input  wire logic                       cfg_we,
  input  wire logic [hcd_pkg::IDX_W-1:0]  cfg_idx,
  input  wire logic [hcd_pkg::ROW_W-1:0]  cfg_wdata
);
  import hcd_pkg::*;

  logic [ROW_W-1:0] row_a_r, row_b_r, row_c_r;
  mat_t             key;

  logic      s1_valid, s1_ready;
  cof_beat_t s1_beat;
  logic      s2_valid, s2_ready;
  det_beat_t s2_beat;
  logic      s3_valid, s3_ready;
  inv_beat_t s3_beat;

  logic [LET_W-1:0] plain_a, plain_b, plain_c;
  logic             status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_a_r <= KEY_ROW_A_RST;
      row_b_r <= KEY_ROW_B_RST;
      row_c_r <= KEY_ROW_C_RST;
    end else if (cfg_we) begin
      if (cfg_idx == REG_KEY_ROW_A) begin
        row_a_r <= cfg_wdata;
      end
      if (cfg_idx == REG_KEY_ROW_B) begin
        row_b_r <= cfg_wdata;
      end
      if (cfg_idx == REG_KEY_ROW_C) begin
        row_c_r <= cfg_wdata;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      key[0][k] = red_entry(row_a_r[DIG_W*k +: DIG_W]);
      key[1][k] = red_entry(row_b_r[DIG_W*k +: DIG_W]);
      key[2][k] = red_entry(row_c_r[DIG_W*k +: DIG_W]);
    end
  end

  hcd_cof u_cof (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .let_a    (in_tdata[6:0]),
    .let_b    (in_tdata[13:7]),
    .let_c    (in_tdata[20:14]),
    .key      (key),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_beat  (s1_beat)
  );

  hcd_det u_det (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_beat  (s1_beat),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_beat  (s2_beat)
  );

  hcd_inv u_inv (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_beat  (s2_beat),
    .dn_valid (s3_valid),
    .dn_ready (s3_ready),
    .dn_beat  (s3_beat)
  );

  hcd_mvmul u_mvmul (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s3_valid),
    .up_ready (s3_ready),
    .up_beat  (s3_beat),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .plain_a  (plain_a),
    .plain_b  (plain_b),
    .plain_c  (plain_c),
    .status   (status)
  );

  assign out_tdata = {3'b000, plain_c, plain_b, plain_a};
  assign out_tuser = status;

`ifndef SYNTH
  // a bad key always yields all-'A' letters
  a_bad_key_letters: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_tdata[6:0] == ASCII_A && out_tdata[13:7] == ASCII_A &&
      out_tdata[20:14] == ASCII_A)
    else $error("bad key beat carries letters other than A");

  // the input only stalls when the output side is holding a beat
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without an output stall");

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // a new output beat must have passed through the pipeline stages
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 4) || $past(s3_valid))
    else $error("output beat appeared without passing the pipeline");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/hcd_cof.sv
// stage 1: letter values and the nine cyclic cofactors of the key, mod 26
// depends on hcd_pkg
`default_nettype none

module hcd_cof (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     up_valid,
  output logic                          up_ready,
  input  wire logic [hcd_pkg::LET_W-1:0] let_a,
  input  wire logic [hcd_pkg::LET_W-1:0] let_b,
  input  wire logic [hcd_pkg::LET_W-1:0] let_c,
  input  wire hcd_pkg::mat_t            key,
  output logic                          dn_valid,
  input  wire logic                     dn_ready,
  output hcd_pkg::cof_beat_t            dn_beat
);
  import hcd_pkg::*;

  logic      v_r;
  cof_beat_t beat_r;
  cof_beat_t beat_nxt;
  logic [9:0] p1, p2;

  always_comb begin
    beat_nxt = '0;
    p1 = '0;
    p2 = '0;
    // (code - 'A') mod 26 == (code + 13) mod 26
    beat_nxt.c[0] = md26(11'(let_a) + 11'd13);
    beat_nxt.c[1] = md26(11'(let_b) + 11'd13);
    beat_nxt.c[2] = md26(11'(let_c) + 11'd13);
    beat_nxt.row0 = key[0];
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        p1 = 10'(key[(r+1)%3][(j+1)%3]) * 10'(key[(r+2)%3][(j+2)%3]);
        p2 = 10'(key[(r+1)%3][(j+2)%3]) * 10'(key[(r+2)%3][(j+1)%3]);
        // bias by 650 keeps the difference non-negative
        beat_nxt.cof[r][j] = md26(11'(p1) + 11'd650 - 11'(p2));
      end
    end
  end

  assign up_ready = ~v_r | dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      beat_r <= beat_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_beat  = beat_r;

endmodule

`default_nettype wire

>>> hw/rtl/hcd_det.sv
// stage 2: determinant mod 26 from row 0 and its cofactors
// depends on hcd_pkg
`default_nettype none

module hcd_det (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire hcd_pkg::cof_beat_t up_beat,
  output logic                    dn_valid,
  input  wire logic               dn_ready,
  output hcd_pkg::det_beat_t      dn_beat
);
  import hcd_pkg::*;

  logic      v_r;
  det_beat_t beat_r;
  det_beat_t beat_nxt;
  logic [10:0] sum;

  always_comb begin
    sum = '0;
    for (int j = 0; j < 3; j++) begin
      sum = sum + 11'(10'(up_beat.row0[j]) * 10'(up_beat.cof[0][j]));
    end
    beat_nxt.c   = up_beat.c;
    beat_nxt.cof = up_beat.cof;
    beat_nxt.det = md26(sum);
  end

  assign up_ready = ~v_r | dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      beat_r <= beat_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_beat  = beat_r;

endmodule

`default_nettype wire

>>> hw/rtl/hcd_inv.sv
// stage 3: key check and inverse matrix, adjugate scaled by det^-1 mod 26
// depends on hcd_pkg
`default_nettype none

module hcd_inv (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire hcd_pkg::det_beat_t up_beat,
  output logic                    dn_valid,
  input  wire logic               dn_ready,
  output hcd_pkg::inv_beat_t      dn_beat
);
  import hcd_pkg::*;

  logic      v_r;
  inv_beat_t beat_r;
  inv_beat_t beat_nxt;
  digit_t    dinv;

  always_comb begin
    dinv = inv26(up_beat.det);
    beat_nxt.c = up_beat.c;
    // even or a multiple of 13 shares a factor with 26
    beat_nxt.bad = ~up_beat.det[0] | (up_beat.det == 5'd13);
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        // adjugate is the transposed cofactor matrix
        beat_nxt.inv[r][j] = md26(11'(10'(dinv) * 10'(up_beat.cof[j][r])));
      end
    end
  end

  assign up_ready = ~v_r | dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      beat_r <= beat_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_beat  = beat_r;

endmodule

`default_nettype wire

>>> hw/rtl/hcd_mvmul.sv
// stage 4: inverse key times letter vector mod 26, ascii output register
// depends on hcd_pkg
`default_nettype none

module hcd_mvmul (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      up_valid,
  output logic                           up_ready,
  input  wire hcd_pkg::inv_beat_t        up_beat,
  output logic                           dn_valid,
  input  wire logic                      dn_ready,
  output logic [hcd_pkg::LET_W-1:0]      plain_a,
  output logic [hcd_pkg::LET_W-1:0]      plain_b,
  output logic [hcd_pkg::LET_W-1:0]      plain_c,
  output logic                           status
);
  import hcd_pkg::*;

  logic               v_r;
  logic [LET_W-1:0]   let_r   [3];
  logic [LET_W-1:0]   let_nxt [3];
  logic               status_r;
  logic [10:0]        acc;

  always_comb begin
    acc = '0;
    for (int r = 0; r < 3; r++) begin
      acc = '0;
      for (int j = 0; j < 3; j++) begin
        acc = acc + 11'(10'(up_beat.inv[r][j]) * 10'(up_beat.c[j]));
      end
      let_nxt[r] = up_beat.bad ? ASCII_A : ASCII_A + LET_W'(md26(acc));
    end
  end

  assign up_ready = ~v_r | dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      let_r    <= let_nxt;
      status_r <= up_beat.bad;
    end
  end

  assign dn_valid = v_r;
  assign plain_a  = let_r[0];
  assign plain_b  = let_r[1];
  assign plain_c  = let_r[2];
  assign status   = status_r;

endmodule

`default_nettype wire
